### sv/msr_pkg.sv
// ---------------------------------------------------------------------------
// msr_pkg: shared types and codes for the shape rasterizer
// Command codes and sequencer states.
// ---------------------------------------------------------------------------
package msr_pkg;

  typedef enum logic [2:0] {
    CMD_RECT   = 3'd0,
    CMD_LINE   = 3'd1,
    CMD_TRI    = 3'd2,
    CMD_CIRCLE = 3'd3,
    CMD_CLEAR  = 3'd4,
    CMD_READ   = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    ST_CLR,   // clearing pass after reset
    ST_IDLE,
    ST_SCAN,  // one canvas pixel per cycle
    ST_RD,    // read-pixel memory access
    ST_OUT
  } state_e;

endpackage

### sv/monochrome_shape_rasterizer.sv
// ---------------------------------------------------------------------------
// monochrome_shape_rasterizer: one-bit framebuffer with shape drawing
// Each command item draws, clears a box or reads one pixel; one result each.
// ---------------------------------------------------------------------------
// Usage:
//  - Slave channel s_axis_* carries one command item; master channel
//    m_axis_* returns exactly one result item per command.
//  - Every drawing command (rectangle, line, triangle, circle, clear box)
//    sweeps the whole canvas, one pixel per cycle through a single shared
//    distance/compare unit, deciding per pixel whether to write it.
//    A read waits in ST_RD for the registered memory data, then goes to ST_OUT.
//  - Diagonal lines and unused codes skip the sweep and go straight to ST_OUT;
//    a diagonal line returns rejected = 1.
//  - Memory: one read and one write port, one pixel per cycle.
//  - After reset the block runs a clearing pass over all ROWS*COLS pixels
//    with s_axis_tready low.
//  - One item at a time: s_axis_tready is low while a command is in work
//    and while the result waits; a stalled m_axis_tready holds the result
//    register and the block until it is taken.
// ---------------------------------------------------------------------------
module monochrome_shape_rasterizer #(
  parameter int CANVAS_ROWS = 32,
  parameter int CANVAS_COLS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // cmd[2:0], x_a[10:3], y_a[18:11], x_b[26:19], y_b[34:27], radius[41:35]
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pixel_set[0], rejected[1]
  output logic [7:0]  m_axis_tdata
);
  import msr_pkg::*;

  localparam int Depth = CANVAS_ROWS * CANVAS_COLS;
  localparam int RW = (CANVAS_ROWS > 1) ? $clog2(CANVAS_ROWS) : 1;
  localparam int CW = (CANVAS_COLS > 1) ? $clog2(CANVAS_COLS) : 1;
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  logic mem [Depth];

  state_e state_q, state_d;
  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] col_q, col_d;
  logic [2:0] cmd_q;
  logic signed [7:0] xa_q, ya_q, xb_q, yb_q;
  logic [6:0] rad_q;
  logic px_q, px_d, rej_q, rej_d, ov_q, ov_d;
  logic rd_q;

  logic acc;
  assign acc = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata = {6'd0, rej_q, px_q};

  // ---- per-pixel shared compare unit (signed 10-bit coordinates) ----
  logic signed [9:0] r, c, xa, ya, xb, yb, xe, ye, lo, hi;
  logic signed [9:0] dx, dy, ti;
  logic signed [17:0] d;
  logic hit, wval, last;

  always_comb begin
    r  = 10'(signed'({1'b0, row_q}));
    c  = 10'(signed'({1'b0, col_q}));
    xa = 10'(xa_q); ya = 10'(ya_q); xb = 10'(xb_q); yb = 10'(yb_q);
    xe = xa + xb - 10'sd1;
    ye = ya + yb - 10'sd1;
    dx = c - xa;
    dy = r - ya;
    ti = r - ya;
    lo = 10'sd0; hi = 10'sd0;
    d  = 18'sd0;
    hit = 1'b0;
    wval = 1'b1;
    case (cmd_q)
      CMD_RECT: begin
        hit = (xb > 0) && (yb > 0) && r >= ya && r <= ye && c >= xa && c <= xe
              && (r == ya || r == ye || c == xa || c == xe);
      end
      CMD_CLEAR: begin
        hit = (xb > 0) && (yb > 0) && r >= ya && r <= ye && c >= xa && c <= xe;
        wval = 1'b0;
      end
      CMD_LINE: begin
        if (ya == yb) begin
          lo = (xa < xb) ? xa : xb;
          hi = (xa < xb) ? xb : xa;
          hit = (r == ya) && c >= lo && c <= hi;
        end else begin
          lo = (ya < yb) ? ya : yb;
          hi = (ya < yb) ? yb : ya;
          hit = (c == xa) && r >= lo && r <= hi;
        end
      end
      CMD_TRI: begin
        // sides: row ya+i, col xa+-i for 0<=i<h; base row ya+h-1
        hit = (yb > 0) && ti >= 0 && ti < yb &&
              ((dx == ti) || (dx == -ti) ||
               ((r == ye) && dx > -yb && dx < yb));
      end
      CMD_CIRCLE: begin
        d = 18'(dx * dx) + 18'(dy * dy) - 18'(rad_q * rad_q);
        if (d < 0) d = -d;
        hit = d <= 18'(signed'({1'b0, rad_q}));
      end
      default: hit = 1'b0;
    endcase
  end

  assign last = (row_q == RW'(CANVAS_ROWS - 1)) && (col_q == CW'(CANVAS_COLS - 1));

  // ---- memory ----
  logic [AW-1:0] waddr, raddr;
  logic we;
  logic rdata_q;
  assign waddr = AW'(row_q) * AW'(CANVAS_COLS) + AW'(col_q);
  assign raddr = AW'(ya_q[RW-1:0]) * AW'(CANVAS_COLS) + AW'(xa_q[CW-1:0]);
  assign we = (state_q == ST_CLR) || (state_q == ST_SCAN && hit);

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= (state_q == ST_CLR) ? 1'b0 : wval;
    rdata_q <= mem[raddr];
  end

  // ---- sequencer ----
  always_comb begin
    state_d = state_q;
    row_d = row_q; col_d = col_q;
    px_d = px_q; rej_d = rej_q; ov_d = ov_q;
    case (state_q)
      ST_CLR, ST_SCAN: begin
        if (last) begin
          row_d = '0; col_d = '0;
          if (state_q == ST_CLR) state_d = ST_IDLE;
          else begin
            state_d = ST_OUT; ov_d = 1'b1;
          end
        end else if (col_q == CW'(CANVAS_COLS - 1)) begin
          col_d = '0; row_d = row_q + RW'(1);
        end else col_d = col_q + CW'(1);
      end
      ST_IDLE: begin
        if (acc) begin
          px_d = 1'b0; rej_d = 1'b0;
          case (s_axis_tdata[2:0])
            CMD_RECT, CMD_TRI, CMD_CIRCLE, CMD_CLEAR: state_d = ST_SCAN;
            CMD_LINE: begin
              if (s_axis_tdata[18:11] != s_axis_tdata[34:27] &&
                  s_axis_tdata[10:3] != s_axis_tdata[26:19]) begin
                rej_d = 1'b1; ov_d = 1'b1; state_d = ST_OUT;
              end else state_d = ST_SCAN;
            end
            CMD_READ: state_d = ST_RD;
            default: begin
              ov_d = 1'b1; state_d = ST_OUT;
            end
          endcase
        end
      end
      ST_RD: begin
        if (rd_q) begin
          px_d = rdata_q &&
                 ya_q >= 0 && 10'(ya_q) < 10'(CANVAS_ROWS) &&
                 xa_q >= 0 && 10'(xa_q) < 10'(CANVAS_COLS);
          ov_d = 1'b1; state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (m_axis_tready) begin
          ov_d = 1'b0; state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
      row_q <= '0; col_q <= '0;
      ov_q <= 1'b0; rd_q <= 1'b0;
      px_q <= 1'b0; rej_q <= 1'b0;
    end else begin
      state_q <= state_d;
      row_q <= row_d; col_q <= col_d;
      ov_q <= ov_d;
      px_q <= px_d; rej_q <= rej_d;
      rd_q <= (state_q == ST_RD) && !rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      cmd_q <= s_axis_tdata[2:0];
      xa_q <= s_axis_tdata[10:3];
      ya_q <= s_axis_tdata[18:11];
      xb_q <= s_axis_tdata[26:19];
      yb_q <= s_axis_tdata[34:27];
      rad_q <= s_axis_tdata[41:35];
    end
  end

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top: stream-level check of the monochrome shape rasterizer
// Commands go in on the slave stream. A canvas model inside the scoreboard
// works out the result that each command should return: the pixel value for
// a read, and the rejected flag for a diagonal line. Both sides idle at
// random, and once the result side holds off for a long stretch.
// ---------------------------------------------------------------------------
module tb_top;
  import msr_pkg::*;

  localparam int ROWS = 32;
  localparam int COLS = 64;
  localparam int NUM_RANDOM = 270;
  // Longer than a full canvas sweep, so the result is always left waiting.
  localparam int LONG_HOLD = 6000;

  typedef struct packed {
    logic pixel_set;
    logic rejected;
  } raster_result_t;

  // Canvas model plus the queue of results still owed by the block.
  class raster_scoreboard;
    bit canvas[ROWS][COLS];
    raster_result_t pending_results[$];
    int mismatches;

    function new();
      mismatches = 0;
      foreach (canvas[r, c]) canvas[r][c] = 1'b0;
    endfunction

    function void put_px(int r, int c, bit v);
      if (r >= 0 && r < ROWS && c >= 0 && c < COLS) canvas[r][c] = v;
    endfunction

    // Outline or solid fill, clipped; an empty box does nothing.
    function void draw_box(int x, int y, int w, int h, bit outline, bit v);
      for (int r = y; r < y + h; r++)
        for (int c = x; c < x + w; c++)
          if (!outline || r == y || r == y + h - 1 || c == x || c == x + w - 1)
            put_px(r, c, v);
    endfunction

    // Returns 1 for a diagonal request, which draws nothing.
    function bit draw_line(int x1, int y1, int x2, int y2);
      int lo;
      int hi;
      if (y1 == y2) begin
        lo = (x1 < x2) ? x1 : x2;
        hi = (x1 < x2) ? x2 : x1;
        for (int i = lo; i <= hi; i++) put_px(y1, i, 1'b1);
        return 1'b0;
      end
      if (x1 == x2) begin
        lo = (y1 < y2) ? y1 : y2;
        hi = (y1 < y2) ? y2 : y1;
        for (int i = lo; i <= hi; i++) put_px(i, x1, 1'b1);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function void draw_triangle(int x, int y, int h);
      for (int i = 0; i < h; i++) begin
        put_px(y + i, x - i, 1'b1);
        put_px(y + i, x + i, 1'b1);
      end
      for (int i = x - h + 1; i <= x + h - 1; i++) put_px(y + h - 1, i, 1'b1);
    endfunction

    // Ring: |dx^2 + dy^2 - rad^2| <= rad.
    function void draw_circle(int cx, int cy, int rad);
      int d;
      for (int r = 0; r < ROWS; r++)
        for (int c = 0; c < COLS; c++) begin
          d = (c - cx) * (c - cx) + (r - cy) * (r - cy) - rad * rad;
          if (d < 0) d = -d;
          if (d <= rad) canvas[r][c] = 1'b1;
        end
    endfunction

    // Called for every accepted command item.
    function void note_command(logic [47:0] d);
      logic [2:0] op;
      int xa, ya, xb, yb, rad;
      raster_result_t res;
      op  = d[2:0];
      xa  = $signed(d[10:3]);
      ya  = $signed(d[18:11]);
      xb  = $signed(d[26:19]);
      yb  = $signed(d[34:27]);
      rad = d[41:35];
      res = '0;
      case (op)
        CMD_RECT:   draw_box(xa, ya, xb, yb, 1'b1, 1'b1);
        CMD_LINE:   res.rejected = draw_line(xa, ya, xb, yb);
        CMD_TRI:    draw_triangle(xa, ya, yb);
        CMD_CIRCLE: draw_circle(xa, ya, rad);
        CMD_CLEAR:  draw_box(xa, ya, xb, yb, 1'b0, 1'b0);
        CMD_READ: begin
          if (ya >= 0 && ya < ROWS && xa >= 0 && xa < COLS)
            res.pixel_set = canvas[ya][xa];
        end
        default: ;
      endcase
      pending_results.push_back(res);
    endfunction

    // Called for every accepted result item.
    function void check_result(logic [7:0] d);
      raster_result_t exp_res;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %h", d);
        return;
      end
      exp_res = pending_results.pop_front();
      if (d[0] !== exp_res.pixel_set || d[1] !== exp_res.rejected) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: pixel_set exp %b got %b, rejected exp %b got %b",
                   exp_res.pixel_set, d[0], exp_res.rejected, d[1]);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;

  raster_scoreboard sb;
  bit sending_done;
  int results_seen;

  monochrome_shape_rasterizer u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Worst case is roughly 290 full canvas sweeps plus the clearing pass
  // and the long hold; the time limit leaves a wide margin.
  initial begin
    #20_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  function automatic logic [47:0] pack_cmd(logic [2:0] op, logic [7:0] xa, logic [7:0] ya,
                                           logic [7:0] xb, logic [7:0] yb,
                                           logic [6:0] rad);
    return {6'd0, rad, yb, xb, ya, xa, op};
  endfunction

  // Coordinates mostly near the canvas, sometimes anywhere in the byte.
  function automatic logic [7:0] rand_col();
    if ($urandom_range(0, 6) == 0) return 8'($urandom);
    return 8'($urandom_range(0, 80) - 8);
  endfunction

  function automatic logic [7:0] rand_row();
    if ($urandom_range(0, 6) == 0) return 8'($urandom);
    return 8'($urandom_range(0, 48) - 8);
  endfunction

  function automatic logic [7:0] rand_size();
    if ($urandom_range(0, 6) == 0) return 8'($urandom);
    return 8'($urandom_range(0, 30) - 2);
  endfunction

  // Reads dominate so that the slow drawing sweeps stay few.
  function automatic logic [47:0] rand_command();
    int pick;
    logic [7:0] xa, ya;
    pick = $urandom_range(0, 99);
    xa = rand_col();
    ya = rand_row();
    if (pick < 55) return pack_cmd(CMD_READ, xa, ya, 8'($urandom), 8'($urandom), 7'($urandom));
    if (pick < 63) return pack_cmd(CMD_RECT, xa, ya, rand_size(), rand_size(), 7'($urandom));
    if (pick < 75) begin
      case ($urandom_range(0, 4))
        0, 1: return pack_cmd(CMD_LINE, xa, ya, rand_col(), ya, 7'($urandom));
        2, 3: return pack_cmd(CMD_LINE, xa, ya, xa, rand_row(), 7'($urandom));
        default: return pack_cmd(CMD_LINE, xa, ya, rand_col(), rand_row(), 7'($urandom));
      endcase
    end
    if (pick < 81) return pack_cmd(CMD_TRI, xa, ya, 8'($urandom), rand_size(), 7'($urandom));
    if (pick < 88) begin
      if ($urandom_range(0, 4) == 0)
        return pack_cmd(CMD_CIRCLE, xa, ya, 8'($urandom), 8'($urandom), 7'($urandom));
      return pack_cmd(CMD_CIRCLE, xa, ya, 8'($urandom), 8'($urandom),
                      7'($urandom_range(0, 20)));
    end
    if (pick < 96) return pack_cmd(CMD_CLEAR, xa, ya, rand_size(), rand_size(), 7'($urandom));
    return pack_cmd(3'($urandom_range(6, 7)), 8'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom), 7'($urandom));
  endfunction

  // Offer one command item after an idle gap; note it once accepted.
  task automatic send_command(logic [47:0] d, int gap);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = d;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_command(d);
    @(negedge clk_i);
  endtask

  // Sender: directed items, then the random body.
  initial begin
    logic [47:0] directed[$];
    int gap;
    sb = new();
    sending_done  = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    rst_ni = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    directed = '{
      pack_cmd(CMD_READ, 8'd0, 8'd0, 8'd0, 8'd0, 7'd0),           // blank after reset
      pack_cmd(CMD_RECT, 8'hFE, 8'hFE, 8'd70, 8'd40, 7'd0),       // clipped on every side
      pack_cmd(CMD_READ, 8'd63, 8'd31, 8'd0, 8'd0, 7'd0),
      pack_cmd(CMD_RECT, 8'd5, 8'd5, 8'd0, 8'd4, 7'd0),           // empty box
      pack_cmd(CMD_LINE, 8'd10, 8'd10, 8'd10, 8'd10, 7'd0),       // single point
      pack_cmd(CMD_READ, 8'd10, 8'd10, 8'd0, 8'd0, 7'd0),
      pack_cmd(CMD_LINE, 8'd3, 8'd3, 8'd9, 8'd7, 7'd0),           // diagonal
      pack_cmd(CMD_LINE, 8'h80, 8'd20, 8'h7F, 8'd20, 7'd0),       // horizontal, full span
      pack_cmd(CMD_LINE, 8'd40, 8'h7F, 8'd40, 8'h80, 7'd0),       // vertical, reversed
      pack_cmd(CMD_TRI, 8'd30, 8'd2, 8'd0, 8'd0, 7'd0),           // flat triangle
      pack_cmd(CMD_TRI, 8'd50, 8'd4, 8'd0, 8'd8, 7'd0),
      pack_cmd(CMD_READ, 8'd50, 8'd11, 8'd0, 8'd0, 7'd0),
      pack_cmd(CMD_CIRCLE, 8'd20, 8'd15, 8'd0, 8'd0, 7'd0),       // zero radius
      pack_cmd(CMD_READ, 8'd20, 8'd15, 8'd0, 8'd0, 7'd0),
      pack_cmd(CMD_CIRCLE, 8'h80, 8'h80, 8'hFF, 8'hFF, 7'h7F),    // extremes
      pack_cmd(CMD_CIRCLE, 8'd32, 8'd16, 8'd0, 8'd0, 7'd10),
      pack_cmd(CMD_READ, 8'd42, 8'd16, 8'd0, 8'd0, 7'd0),
      pack_cmd(CMD_CLEAR, 8'd30, 8'd10, 8'd20, 8'd10, 7'd0),
      pack_cmd(CMD_READ, 8'd42, 8'd16, 8'd0, 8'd0, 7'd0),
      pack_cmd(CMD_READ, 8'hFF, 8'd5, 8'd0, 8'd0, 7'd0),          // off canvas
      pack_cmd(CMD_READ, 8'd5, 8'h7F, 8'hFF, 8'hFF, 7'h7F),
      pack_cmd(3'd6, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 7'h7F),          // unused codes
      pack_cmd(3'd7, 8'd1, 8'd1, 8'd1, 8'd1, 7'd1),
      pack_cmd(CMD_CLEAR, 8'h80, 8'h80, 8'h7F, 8'h7F, 7'd0)       // ends just off canvas, clears nothing
    };
    foreach (directed[i]) send_command(directed[i], $urandom_range(0, 7));

    for (int i = 0; i < NUM_RANDOM; i++) begin
      // Every fourth block of 20 items runs back to back.
      gap = ((i / 20) % 4 == 1) ? 0 : $urandom_range(0, 7);
      send_command(rand_command(), gap);
    end
    s_axis_tvalid = 1'b0;
    sending_done  = 1'b1;
  end

  // Receiver: random stalls, no stalls for a stretch, and one long hold.
  initial begin
    int stall;
    results_seen  = 0;
    m_axis_tready = 1'b0;
    forever begin
      if (results_seen == 40) stall = LONG_HOLD;
      else if ((results_seen / 25) % 4 == 2) stall = 0;
      else stall = $urandom_range(0, 7);
      if (stall > 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_result(m_axis_tdata);
      results_seen++;
      @(negedge clk_i);
    end
  end

  // Wrap up once everything sent has come back, plus a short tail for strays.
  initial begin
    wait (sending_done);
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
